// ===== rtl/deq_pkg.sv =====
// ----------------------------------------------------------------------------
// deq_pkg: shared types and constants of the double-ended queue
// Request and response payloads, request codes, and the command and status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package deq_pkg;

	localparam int WORD_W = 32;
	localparam int FILL_W = 5;
	localparam int REQ_W  = 3;

	// Request codes
	localparam logic [REQ_W-1:0] REQ_PUSH_HEAD = 3'd0;
	localparam logic [REQ_W-1:0] REQ_PUSH_TAIL = 3'd1;
	localparam logic [REQ_W-1:0] REQ_POP_HEAD  = 3'd2;
	localparam logic [REQ_W-1:0] REQ_POP_TAIL  = 3'd3;
	localparam logic [REQ_W-1:0] REQ_SEARCH    = 3'd4;

	// Word reported for an empty store or a failed pop (-1)
	localparam logic signed [WORD_W-1:0] NONE_WORD = '1;

	typedef struct packed {
		logic [REQ_W-1:0]         req_type;
		logic signed [WORD_W-1:0] data_value;
	} deq_req_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] popped_value;
		logic                     pop_on_empty;
		logic                     push_dropped;
		logic                     found;
		logic signed [WORD_W-1:0] front_value;
		logic signed [WORD_W-1:0] back_value;
		logic                     now_empty;
		logic [FILL_W-1:0]        fill_count;
	} deq_rsp_t;

	// Controller to datapath
	typedef struct packed {
		logic latch_req;  // take the incoming request
		logic do_exec;    // apply the request to the store
		logic cap_pop;    // capture the popped word
		logic srch_step;  // compare one entry, fetch the next
		logic rd_front;   // read the head entry
		logic rd_back;    // capture head, read the tail entry
		logic out_load;   // load the response register
	} deq_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic is_pop;
		logic is_search;
		logic empty;
		logic match;
		logic last;
	} deq_sts_t;

endpackage

// ===== rtl/deq_ram.sv =====
// ----------------------------------------------------------------------------
// deq_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds when idle.
// ----------------------------------------------------------------------------
module deq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/deq_dpath.sv =====
// ----------------------------------------------------------------------------
// deq_dpath: datapath of the double-ended queue
// Head pointer, entry count, ring addressing, entry store and response word.
// ----------------------------------------------------------------------------
module deq_dpath import deq_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	input  deq_req_t req,
	input  deq_cmd_t cmd,
	output deq_sts_t sts,
	output deq_rsp_t rsp
);

	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int SUM_W  = CNT_W + 1;

	logic [ADDR_W-1:0] front_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  idx_q;
	deq_req_t          req_q;
	logic [WORD_W-1:0] popped_q;
	logic [WORD_W-1:0] front_val_q;
	logic              pop_empty_q;
	logic              dropped_q;
	logic              hit_q;
	deq_rsp_t          rsp_q;

	logic              empty;
	logic              full;
	logic [CNT_W-1:0]  back_off;
	logic [CNT_W-1:0]  idx_next;
	logic [ADDR_W-1:0] head_slot;
	logic [ADDR_W-1:0] tail_slot;
	logic [ADDR_W-1:0] last_slot;
	logic [ADDR_W-1:0] next_slot;
	logic [ADDR_W-1:0] step_slot;
	logic              we;
	logic [ADDR_W-1:0] waddr;
	logic              re;
	logic [ADDR_W-1:0] raddr;
	logic [WORD_W-1:0] rdata;

	// Ring position base + off, with off at most DEPTH
	function automatic logic [ADDR_W-1:0] slot(input logic [ADDR_W-1:0] base,
			input logic [CNT_W-1:0] off);
		logic [SUM_W-1:0] sum;
		sum = SUM_W'(base) + SUM_W'(off);
		if (sum >= SUM_W'(DEPTH)) begin
			sum = sum - SUM_W'(DEPTH);
		end
		return sum[ADDR_W-1:0];
	endfunction

	assign empty     = (count_q == '0);
	assign full      = (count_q == CNT_W'(DEPTH));
	assign back_off  = empty ? '0 : count_q - 1'b1;
	assign idx_next  = idx_q + 1'b1;
	assign head_slot = (front_q == '0) ? ADDR_W'(DEPTH - 1) : front_q - 1'b1;
	assign tail_slot = slot(front_q, count_q);
	assign last_slot = slot(front_q, back_off);
	assign next_slot = slot(front_q, CNT_W'(1));
	assign step_slot = slot(front_q, idx_next);

	always_comb begin
		sts.is_pop    = 1'b0;
		sts.is_search = 1'b0;
		case (req_q.req_type) inside
			REQ_POP_HEAD, REQ_POP_TAIL: sts.is_pop = 1'b1;
			REQ_SEARCH:                 sts.is_search = 1'b1;
			default: ;
		endcase
		sts.empty = empty;
		sts.match = (rdata == req_q.data_value);
		sts.last  = (idx_next == count_q);
	end

	// Store port selection
	always_comb begin
		we    = 1'b0;
		waddr = head_slot;
		re    = 1'b0;
		raddr = front_q;
		if (cmd.do_exec) begin
			case (req_q.req_type)
				REQ_PUSH_HEAD: begin
					we    = !full;
					waddr = head_slot;
				end
				REQ_PUSH_TAIL: begin
					we    = !full;
					waddr = tail_slot;
				end
				REQ_POP_HEAD: begin
					re    = !empty;
					raddr = front_q;
				end
				REQ_POP_TAIL: begin
					re    = !empty;
					raddr = last_slot;
				end
				REQ_SEARCH: begin
					re    = !empty;
					raddr = front_q;
				end
				default: ;
			endcase
		end else if (cmd.rd_front) begin
			re    = 1'b1;
			raddr = front_q;
		end else if (cmd.rd_back) begin
			re    = 1'b1;
			raddr = last_slot;
		end else if (cmd.srch_step) begin
			re    = 1'b1;
			raddr = step_slot;
		end
	end

	deq_ram #(
		.WIDTH(WORD_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(req_q.data_value),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	// Head pointer and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			count_q <= '0;
		end else if (cmd.do_exec) begin
			case (req_q.req_type)
				REQ_PUSH_HEAD: begin
					if (!full) begin
						front_q <= head_slot;
						count_q <= count_q + 1'b1;
					end
				end
				REQ_PUSH_TAIL: begin
					if (!full) begin
						count_q <= count_q + 1'b1;
					end
				end
				REQ_POP_HEAD: begin
					if (!empty) begin
						front_q <= next_slot;
						count_q <= count_q - 1'b1;
					end
				end
				REQ_POP_TAIL: begin
					if (!empty) begin
						count_q <= count_q - 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// Request, flags and response payload
	always_ff @(posedge clk) begin
		if (cmd.latch_req) begin
			req_q <= req;
		end
		if (cmd.do_exec) begin
			popped_q    <= '0;
			pop_empty_q <= 1'b0;
			dropped_q   <= 1'b0;
			hit_q       <= 1'b0;
			idx_q       <= '0;
			case (req_q.req_type) inside
				REQ_PUSH_HEAD, REQ_PUSH_TAIL: dropped_q <= full;
				REQ_POP_HEAD, REQ_POP_TAIL: begin
					if (empty) begin
						popped_q    <= NONE_WORD;
						pop_empty_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
		if (cmd.cap_pop) begin
			popped_q <= rdata;
		end
		if (cmd.srch_step) begin
			idx_q <= idx_next;
			if (sts.match) begin
				hit_q <= 1'b1;
			end
		end
		if (cmd.rd_back) begin
			front_val_q <= rdata;
		end
		if (cmd.out_load) begin
			rsp_q.popped_value <= popped_q;
			rsp_q.pop_on_empty <= pop_empty_q;
			rsp_q.push_dropped <= dropped_q;
			rsp_q.found        <= hit_q;
			rsp_q.front_value  <= empty ? NONE_WORD : front_val_q;
			rsp_q.back_value   <= empty ? NONE_WORD : rdata;
			rsp_q.now_empty    <= empty;
			rsp_q.fill_count   <= FILL_W'(count_q);
		end
	end

	assign rsp = rsp_q;

endmodule

// ===== rtl/deq_ctrl.sv =====
// ----------------------------------------------------------------------------
// deq_ctrl: sequencer of the double-ended queue
// Steps each request through execute, pop capture or search, status reads and response.
// ----------------------------------------------------------------------------
module deq_ctrl import deq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	input  deq_sts_t sts,
	output deq_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_POP_CAP,
		ST_SRCH,
		ST_FRONT_RD,
		ST_BACK_RD,
		ST_FIN
	} state_t;

	state_t state_q;
	logic   rsp_valid_q;
	logic   rsp_free;
	logic   srch_done;

	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign srch_done = sts.match || sts.last;
	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		cmd           = '0;
		cmd.latch_req = (state_q == ST_IDLE) && req_valid;
		cmd.do_exec   = (state_q == ST_EXEC);
		cmd.cap_pop   = (state_q == ST_POP_CAP);
		cmd.srch_step = (state_q == ST_SRCH);
		cmd.rd_front  = (state_q == ST_FRONT_RD) || (state_q == ST_POP_CAP) ||
			((state_q == ST_SRCH) && srch_done);
		cmd.rd_back   = (state_q == ST_BACK_RD);
		cmd.out_load  = (state_q == ST_FIN) && rsp_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (sts.is_pop && !sts.empty) begin
						state_q <= ST_POP_CAP;
					end else if (sts.is_search && !sts.empty) begin
						state_q <= ST_SRCH;
					end else begin
						state_q <= ST_FRONT_RD;
					end
				end
				ST_POP_CAP:  state_q <= ST_BACK_RD;
				ST_SRCH: begin
					if (srch_done) begin
						state_q <= ST_BACK_RD;
					end
				end
				ST_FRONT_RD: state_q <= ST_BACK_RD;
				ST_BACK_RD:  state_q <= ST_FIN;
				ST_FIN: begin
					if (rsp_free) begin
						state_q <= ST_IDLE;
					end
				end
				default:     state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/double_ended_queue_core.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue_core: bounded double-ended queue of 32-bit words
// Ring store of DEPTH entries with push and pop at both ends and a search.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake            | payload
//  request   | in        | req_valid/req_stall  | req (req_type, data_value)
//  response  | out       | rsp_valid/rsp_stall  | rsp (popped, flags, head, tail,
//            |           |                      |      empty, fill count)
//
//  Sequence: a push, a pop or an unknown code runs execute, a head read or
//  pop capture, a tail read and the response step before the next request
//  is accepted; a search on N held entries compares entries in order up to
//  the first match, or all N. The shared single-read-port entry store sets
//  this order: one entry is compared per read, head and tail are read one at a time.
//  Reset: pointer, count and handshake state clear at once; the store is
//  never cleared, and requests are taken from the first cycle after reset.
//  Stalls: a finished response waits in the output register while the next
//  request is accepted; the sequencer holds only when a second response is
//  ready and the first still has not been taken.
// ----------------------------------------------------------------------------
module double_ended_queue_core import deq_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	input  deq_req_t req,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	output deq_rsp_t rsp
);

	// Command and status bundles between sequencer and datapath
	deq_cmd_t cmd;
	deq_sts_t sts;

	// Sequencer: drives the handshake and the command bundle for each step
	deq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Datapath: head pointer, entry count, entry store and the response register
	deq_dpath #(
		.DEPTH(DEPTH)
	) u_dpath (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.cmd   (cmd),
		.sts   (sts),
		.rsp   (rsp)
	);

endmodule

// ===== rtl/deq_checker.sv =====
// ----------------------------------------------------------------------------
// deq_checker: port-level checks of the double-ended queue
// Watches both channels and the consistency of each response.
// ----------------------------------------------------------------------------
module deq_checker import deq_pkg::*; #(
	parameter int DEPTH = 16
) (
	input logic     clk,
	input logic     arst_n,
	input logic     req_valid,
	input logic     req_stall,
	input logic     rsp_valid,
	input logic     rsp_stall,
	input deq_rsp_t rsp
);

	// Hold off the next request in the cycle after taking one
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> req_stall)
		else $error("request taken in back-to-back cycles");

	// Hold a stalled response
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
		else $error("stalled response changed");

	// Empty store reports -1 at both ends
	a_empty_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.now_empty) |->
		(rsp.front_value == NONE_WORD && rsp.back_value == NONE_WORD))
		else $error("empty response with head or tail value");

	// A failed pop leaves the store empty and reports -1
	a_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.pop_on_empty) |->
		(rsp.now_empty && rsp.popped_value == NONE_WORD && !rsp.push_dropped))
		else $error("pop on empty with inconsistent response");

	// Empty flag agrees with the count while the count fits its field
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> ((DEPTH >= 32) || (rsp.now_empty == (rsp.fill_count == '0))))
		else $error("empty flag disagrees with fill count");

endmodule

bind double_ended_queue_core deq_checker #(
	.DEPTH(DEPTH)
) u_deq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req_valid),
	.req_stall(req_stall),
	.rsp_valid(rsp_valid),
	.rsp_stall(rsp_stall),
	.rsp      (rsp)
);
